/* hdl/mhtq_pkg.sv */
// Package: shared types, constants and status codes of the timer queue.
`timescale 1ns / 1ps
`default_nettype none
package mhtq_pkg;
    localparam int Capacity  = 64;
    localparam int SlotW     = $clog2(Capacity);
    localparam int CountW    = $clog2(Capacity + 1);
    localparam int IdW       = 6;
    localparam int IdCount   = 64;
    localparam int TimeW     = 32;

    typedef logic [1:0]        t_opcode;
    typedef logic [IdW-1:0]    t_id;
    typedef logic [TimeW-1:0]  t_time;
    typedef logic [2:0]        t_status;
    typedef logic [SlotW-1:0]  t_slot;
    typedef logic [CountW-1:0] t_count;

    localparam t_opcode OP_ADD    = 2'd0;
    localparam t_opcode OP_ADJUST = 2'd1;
    localparam t_opcode OP_DELETE = 2'd2;
    localparam t_opcode OP_TICK   = 2'd3;

    localparam t_status ST_DONE    = 3'd0;
    localparam t_status ST_EXPIRED = 3'd1;
    localparam t_status ST_NONE    = 3'd2;
    localparam t_status ST_FULL    = 3'd3;
    localparam t_status ST_UNKNOWN = 3'd4;
    localparam t_status ST_IN_USE  = 3'd5;

    typedef struct packed {
        t_opcode opcode;
        t_id     timer_id;
        t_time   expire_time;
        t_time   now_time;
    } t_req;

    typedef struct packed {
        t_status status;
        t_id     expired_id;
        t_time   expired_time;
        logic    last;
    } t_rsp;

    // One heap slot as stored in memory.
    typedef struct packed {
        t_time expiry;
        t_id   owner;
    } t_entry;
endpackage
`default_nettype wire

/* hdl/mhtq_if.sv */
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface mhtq_req_if;
    logic              valid;
    logic              ready;
    mhtq_pkg::t_req    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mhtq_rsp_if;
    logic              valid;
    logic              ready;
    mhtq_pkg::t_rsp    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/mhtq_ram.sv */
// Generic single-write, dual-read synchronous RAM with registered reads.
`timescale 1ns / 1ps
`default_nettype none
module mhtq_ram #(
    parameter int Width = 8,
    parameter int Depth = 64,
    localparam int AddrW = $clog2(Depth)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [Width-1:0] i_wdata,
    input  wire logic [AddrW-1:0] i_raddr_a,
    input  wire logic [AddrW-1:0] i_raddr_b,
    output logic      [Width-1:0] o_rdata_a,
    output logic      [Width-1:0] o_rdata_b
);
    logic [Width-1:0] r_mem [Depth];

    // Write one word and read two words through registered outputs.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

/* hdl/min_heap_timer_queue_core.sv */
// Top level: timer queue sequencer around the heap and position memories.
`timescale 1ns / 1ps
`default_nettype none
// Timer queue held as a binary min-heap of up to 64 timers in a slot RAM, with a
// second RAM mapping each timer id to its slot. One request is taken at a time.
// Every heap level of a sift is a read step and a compare step, and each swap is
// written back as the partner move and then the moving entry's move; add writes the
// timer at the tail and sifts it up, adjust rewrites it in place and re-sifts it, delete
// moves the tail into the freed slot, and a tick repeats that removal per expired timer. A result
// waits in an output register; the next request is taken once the last result of
// the current one has left. No clearing pass is needed after reset.
module min_heap_timer_queue_core (
    input wire logic i_clk,
    input wire logic i_rst_n,
    mhtq_req_if.sink   s_req,
    mhtq_rsp_if.source m_rsp
);
    import mhtq_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CHECK  = 5'd1;
    localparam logic [4:0] S_ADDW   = 5'd2;
    localparam logic [4:0] S_RDCUR  = 5'd3;
    localparam logic [4:0] S_UPRD   = 5'd4;
    localparam logic [4:0] S_UPCMP  = 5'd5;
    localparam logic [4:0] S_SWW1   = 5'd6;
    localparam logic [4:0] S_SWW2   = 5'd7;
    localparam logic [4:0] S_DNRD   = 5'd8;
    localparam logic [4:0] S_DNCMP  = 5'd9;
    localparam logic [4:0] S_RESP   = 5'd10;
    localparam logic [4:0] S_WAIT   = 5'd11;
    localparam logic [4:0] S_TKRD   = 5'd12;
    localparam logic [4:0] S_TKCMP  = 5'd13;
    localparam logic [4:0] S_RMRD   = 5'd14;
    localparam logic [4:0] S_RMMV   = 5'd15;
    localparam logic [4:0] S_RSRD   = 5'd16;
    localparam logic [4:0] S_RSCMP  = 5'd17;
    localparam logic [4:0] S_ADJW   = 5'd18;

    logic [4:0] r_state, n_state;
    logic [4:0] r_after;           // state to go to after a swap write
    logic       r_down;            // swap belongs to a sift down
    t_req       r_req;
    t_count     r_count;
    logic [IdCount-1:0] r_active;
    t_slot      r_cur, r_oth;      // slot being sifted and its partner
    t_entry     r_ecur, r_eoth;
    logic       r_tick_any;
    logic       r_out_valid;
    t_rsp       r_out;
    logic       r_hold;            // an expired beat waits for its last flag
    t_rsp       r_held;

    // Heap slot RAM and id-to-slot RAM.
    logic   heap_we;
    t_slot  heap_wa, heap_ra, heap_rb;
    t_entry heap_wd, heap_qa, heap_qb;
    logic   pos_we;
    t_id    pos_wa, pos_ra;
    t_slot  pos_wd, pos_qa, pos_qb;

    mhtq_ram #(.Width($bits(t_entry)), .Depth(Capacity)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_wa), .i_wdata(heap_wd),
        .i_raddr_a(heap_ra), .i_raddr_b(heap_rb),
        .o_rdata_a(heap_qa), .o_rdata_b(heap_qb)
    );
    mhtq_ram #(.Width(SlotW), .Depth(IdCount)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_wa), .i_wdata(pos_wd),
        .i_raddr_a(pos_ra), .i_raddr_b(pos_ra),
        .o_rdata_a(pos_qa), .o_rdata_b(pos_qb)
    );

    t_slot  cur_parent, left_c, right_c, tail;
    t_count left_w, right_w;
    assign cur_parent = SlotW'((r_cur - t_slot'(1)) >> 1);
    assign left_w     = {r_cur, 1'b1};
    assign right_w    = left_w + t_count'(1);
    assign left_c     = left_w[SlotW-1:0];
    assign right_c    = right_w[SlotW-1:0];
    assign tail       = SlotW'(r_count - t_count'(1));

    assign s_req.ready  = (r_state == S_IDLE);
    assign m_rsp.valid  = r_out_valid;
    assign m_rsp.data   = r_out;

    logic   set_out;
    t_rsp   out_d;
    logic   act_set, act_clr;
    t_id    act_id;
    t_count n_count;
    t_slot  n_cur, n_oth;
    t_entry n_ecur, n_eoth;
    logic   n_down, n_tick_any;
    logic [4:0] n_after;
    logic   sel_right;

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_down = r_down;
        n_count = r_count;
        n_cur = r_cur;
        n_oth = r_oth;
        n_ecur = r_ecur;
        n_eoth = r_eoth;
        n_tick_any = r_tick_any;
        set_out = 1'b0;
        out_d = '0;
        act_set = 1'b0;
        act_clr = 1'b0;
        act_id = r_req.timer_id;
        heap_we = 1'b0;
        heap_wa = r_cur;
        heap_wd = r_ecur;
        heap_ra = r_cur;
        heap_rb = r_oth;
        pos_we = 1'b0;
        pos_wa = r_ecur.owner;
        pos_wd = r_cur;
        pos_ra = r_req.timer_id;
        sel_right = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                pos_ra = s_req.data.timer_id;
                if (s_req.valid) begin
                    n_tick_any = 1'b0;
                    n_state = (s_req.data.opcode == OP_TICK) ? S_TKRD : S_CHECK;
                end
            end
            // Position of the named id is now read out.
            S_CHECK: begin
                unique case (r_req.opcode) inside
                    OP_ADD: begin
                        if (r_active[r_req.timer_id]) begin
                            set_out = 1'b1;
                            out_d.status = ST_IN_USE;
                        end else if (r_count == t_count'(Capacity)) begin
                            set_out = 1'b1;
                            out_d.status = ST_FULL;
                        end else begin
                            n_cur = SlotW'(r_count);
                            n_ecur = '{expiry: r_req.expire_time, owner: r_req.timer_id};
                            n_count = r_count + t_count'(1);
                            n_state = S_ADDW;
                        end
                    end
                    OP_ADJUST, OP_DELETE: begin
                        if (!r_active[r_req.timer_id]) begin
                            set_out = 1'b1;
                            out_d.status = ST_UNKNOWN;
                        end else begin
                            n_cur = pos_qa;
                            if (r_req.opcode == OP_ADJUST) begin
                                n_ecur = '{expiry: r_req.expire_time,
                                           owner: r_req.timer_id};
                                n_state = S_ADJW;
                            end else begin
                                n_state = S_RMRD;
                            end
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
                if (set_out) begin
                    out_d.last = 1'b1;
                    n_state = S_WAIT;
                end
            end
            // Write the new timer at the tail, then sift it up.
            S_ADDW: begin
                heap_we = 1'b1;
                pos_we = 1'b1;
                act_set = 1'b1;
                n_state = S_UPRD;
            end
            // Write the entry in place and point its id at it, then decide the direction.
            S_ADJW: begin
                heap_we = 1'b1;
                pos_we = 1'b1;
                n_state = S_RSRD;
            end
            // Read parent for sift up.
            S_UPRD: begin
                if (r_cur == '0) begin
                    n_state = S_RESP;
                end else begin
                    heap_rb = cur_parent;
                    n_oth = cur_parent;
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (heap_qb.expiry <= r_ecur.expiry) begin
                    n_state = S_RESP;
                end else begin
                    n_eoth = heap_qb;
                    n_down = 1'b0;
                    n_after = S_UPRD;
                    n_state = S_SWW1;
                end
            end
            // Swap: put the partner entry in the current slot.
            S_SWW1: begin
                heap_we = 1'b1;
                heap_wa = r_cur;
                heap_wd = r_eoth;
                pos_we = 1'b1;
                pos_wa = r_eoth.owner;
                pos_wd = r_cur;
                n_state = S_SWW2;
            end
            // Swap: the moving entry lands in the partner slot and follows it.
            S_SWW2: begin
                heap_we = 1'b1;
                heap_wa = r_oth;
                heap_wd = r_ecur;
                pos_we = 1'b1;
                pos_wa = r_ecur.owner;
                pos_wd = r_oth;
                n_cur = r_oth;
                n_state = r_after;
            end
            // Read both children for sift down.
            S_DNRD: begin
                if (left_w >= r_count) begin
                    n_state = S_RESP;
                end else begin
                    heap_ra = left_c;
                    heap_rb = right_c;
                    n_state = S_DNCMP;
                end
            end
            S_DNCMP: begin
                sel_right = (right_w < r_count) && (heap_qb.expiry < heap_qa.expiry);
                n_eoth = sel_right ? heap_qb : heap_qa;
                n_oth = sel_right ? right_c : left_c;
                if (r_ecur.expiry <= n_eoth.expiry) begin
                    n_state = S_RESP;
                end else begin
                    n_down = 1'b1;
                    n_after = S_DNRD;
                    n_state = S_SWW1;
                end
            end
            // Removal: read the victim slot and the tail slot.
            S_RMRD: begin
                heap_ra = r_cur;
                heap_rb = tail;
                n_oth = tail;
                n_state = S_RMMV;
            end
            S_RMMV: begin
                act_clr = 1'b1;
                act_id = heap_qa.owner;
                n_count = r_count - t_count'(1);
                if (r_cur == tail) begin
                    n_state = S_RESP;
                end else begin
                    // Move the tail into the freed slot, then re-sift it.
                    n_ecur = heap_qb;
                    n_state = S_ADJW;
                end
            end
            // Re-sift: read parent to choose direction.
            S_RSRD: begin
                if (r_cur == '0) begin
                    n_state = S_DNRD;
                end else begin
                    heap_rb = cur_parent;
                    n_state = S_RSCMP;
                end
            end
            S_RSCMP: begin
                if (r_ecur.expiry < heap_qb.expiry) begin
                    n_eoth = heap_qb;
                    n_oth = cur_parent;
                    n_down = 1'b0;
                    n_after = S_UPRD;
                    n_state = S_SWW1;
                end else begin
                    n_state = S_DNRD;
                end
            end
            // Tick: read the root.
            S_TKRD: begin
                heap_ra = '0;
                n_state = S_TKCMP;
            end
            S_TKCMP: begin
                if (r_count != '0 && heap_qa.expiry <= r_req.now_time) begin
                    set_out = 1'b1;
                    out_d.status = ST_EXPIRED;
                    out_d.expired_id = heap_qa.owner;
                    out_d.expired_time = heap_qa.expiry;
                    n_tick_any = 1'b1;
                    n_cur = '0;
                    n_state = S_WAIT;
                end else begin
                    set_out = 1'b1;
                    out_d.last = 1'b1;
                    out_d.status = ST_NONE;
                    n_state = S_WAIT;
                    if (r_tick_any) begin
                        // Mark the previous expiry result as the last one.
                        set_out = 1'b0;
                    end
                end
            end
            // Done with add, adjust or delete; during a tick, go back to read the new root.
            S_RESP: begin
                if (r_req.opcode == OP_TICK) begin
                    n_state = S_TKRD;
                end else begin
                    set_out = 1'b1;
                    out_d.status = ST_DONE;
                    out_d.last = 1'b1;
                    n_state = S_WAIT;
                end
            end
            // Hold until the result beat is taken.
            S_WAIT: begin
                if (!r_out_valid || m_rsp.ready) begin
                    if (r_req.opcode == OP_TICK && r_hold) begin
                        n_state = S_RMRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Ticks only know the last expiry once the next root fails: look ahead.
    // To keep last exact, an expired beat is held back until the follow-up check.
    logic   flush_last;
    assign flush_last = (r_state == S_TKCMP) && r_tick_any &&
                        !(r_count != '0 && heap_qa.expiry <= r_req.now_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_active <= '0;
            r_out_valid <= 1'b0;
            r_hold <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (act_set) r_active[act_id] <= 1'b1;
            if (act_clr) r_active[act_id] <= 1'b0;
            if (set_out && out_d.status == ST_EXPIRED) begin
                // Release any earlier held expiry, hold the new one.
                if (r_hold) begin
                    r_out_valid <= 1'b1;
                    r_out <= r_held;
                end else if (m_rsp.valid && m_rsp.ready) begin
                    r_out_valid <= 1'b0;
                end
                r_hold <= 1'b1;
                r_held <= out_d;
            end else if (flush_last) begin
                r_out_valid <= 1'b1;
                r_out <= '{status: r_held.status, expired_id: r_held.expired_id,
                           expired_time: r_held.expired_time, last: 1'b1};
                r_hold <= 1'b0;
            end else if (set_out) begin
                r_out_valid <= 1'b1;
                r_out <= out_d;
            end else if (m_rsp.valid && m_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_req.valid && s_req.ready) r_req <= s_req.data;
        r_after <= n_after;
        r_down <= n_down;
        r_cur <= n_cur;
        r_oth <= n_oth;
        r_ecur <= n_ecur;
        r_eoth <= n_eoth;
        r_tick_any <= n_tick_any;
    end

    // Status codes stay within the defined range.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status <= ST_IN_USE))
        else $error("result status out of range");
    // The heap never grows beyond capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(Capacity))
        else $error("entry count above capacity");
    // A new request is never taken while a result is pending in a wait.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> !s_req.ready)
        else $error("request accepted while busy");
    // Sift direction bookkeeping: an up swap returns to the parent read.
    a_swap_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWW2 && !r_down) |-> (r_after == S_UPRD))
        else $error("sift up swap has wrong return state");
endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for the timer queue core: directed table, random traffic, predicted heap.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import mhtq_pkg::*;

    logic i_clk;
    logic i_rst_n;

    mhtq_req_if req_ch ();
    mhtq_rsp_if rsp_ch ();

    min_heap_timer_queue_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_req  (req_ch.sink),
        .m_rsp  (rsp_ch.source)
    );

    // Predicted queue contents
    t_time  heap_exp [Capacity];
    t_id    heap_own [Capacity];
    t_slot  slot_of  [IdCount];
    bit     live     [IdCount];
    int     heap_n;

    // Predicted results not yet seen
    t_rsp   pending_rsp[$];
    // Directed rows with a typed result to check on top of the prediction
    t_rsp   typed_rsp[$];
    bit     typed_flag[$];

    int     errors;
    int     idle_cycles;
    bit     stim_done;

    // Directed table
    typedef struct {
        t_req req;
        bit   has_typed;
        t_rsp typed;
    } t_row;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Append one predicted result
    function automatic void expect_rsp(t_rsp r);
        pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    // Swap two heap slots and their id map entries
    function automatic void swap_pos(int a, int b);
        t_time te;
        t_id   to;
        te = heap_exp[a]; to = heap_own[a];
        heap_exp[a] = heap_exp[b]; heap_own[a] = heap_own[b];
        heap_exp[b] = te; heap_own[b] = to;
        slot_of[heap_own[a]] = t_slot'(a);
        slot_of[heap_own[b]] = t_slot'(b);
    endfunction

    function automatic void bubble_up(int h);
        int p;
        while (h > 0) begin
            p = (h - 1) / 2;
            if (heap_exp[p] <= heap_exp[h]) break;
            swap_pos(p, h);
            h = p;
        end
    endfunction

    function automatic void bubble_down(int h);
        int c;
        while (h < heap_n) begin
            c = 2 * h + 1;
            if (c >= heap_n) break;
            if (c + 1 < heap_n && heap_exp[c + 1] < heap_exp[c]) c++;
            if (heap_exp[h] <= heap_exp[c]) break;
            swap_pos(h, c);
            h = c;
        end
    endfunction

    function automatic void reheap(int pos);
        if (pos == 0) bubble_down(0);
        else if (heap_exp[pos] < heap_exp[(pos - 1) / 2]) bubble_up(pos);
        else bubble_down(pos);
    endfunction

    function automatic void drop_at(int pos);
        int tail;
        tail = heap_n - 1;
        live[heap_own[pos]] = 1'b0;
        if (pos == tail) begin
            heap_n = tail;
        end else begin
            swap_pos(pos, tail);
            heap_n = tail;
            reheap(pos);
        end
    endfunction

    function automatic t_rsp mk(t_status s, t_id id, t_time t, logic l);
        t_rsp r;
        r.status = s; r.expired_id = id; r.expired_time = t; r.last = l;
        return r;
    endfunction

    // Update the predicted queue for one request and queue its results
    function automatic void queue_results(t_req q);
        int pos;
        int k;
        case (q.opcode) inside
            OP_ADD: begin
                if (live[q.timer_id]) expect_rsp(mk(ST_IN_USE, '0, '0, 1'b1));
                else if (heap_n >= Capacity) expect_rsp(mk(ST_FULL, '0, '0, 1'b1));
                else begin
                    pos = heap_n;
                    heap_exp[pos] = q.expire_time;
                    heap_own[pos] = q.timer_id;
                    slot_of[q.timer_id] = t_slot'(pos);
                    live[q.timer_id] = 1'b1;
                    heap_n++;
                    bubble_up(pos);
                    expect_rsp(mk(ST_DONE, '0, '0, 1'b1));
                end
            end
            OP_ADJUST, OP_DELETE: begin
                if (!live[q.timer_id]) begin
                    expect_rsp(mk(ST_UNKNOWN, '0, '0, 1'b1));
                end else begin
                    pos = slot_of[q.timer_id];
                    if (q.opcode == OP_ADJUST) begin
                        heap_exp[pos] = q.expire_time;
                        reheap(pos);
                    end else begin
                        drop_at(pos);
                    end
                    expect_rsp(mk(ST_DONE, '0, '0, 1'b1));
                end
            end
            default: begin
                k = 0;
                while (heap_n > 0 && heap_exp[0] <= q.now_time) begin
                    expect_rsp(mk(ST_EXPIRED, heap_own[0], heap_exp[0], 1'b0));
                    drop_at(0);
                    k++;
                end
                if (k == 0) expect_rsp(mk(ST_NONE, '0, '0, 1'b1));
                else pending_rsp[$].last = 1'b1;
            end
        endcase
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_time rnd_time();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return t_time'($urandom);
            default: return t_time'($urandom_range(0, 200));
        endcase
    endfunction

    // Pick a live id when possible
    function automatic t_id live_id();
        t_id id;
        for (int i = 0; i < 8; i++) begin
            id = t_id'($urandom_range(0, IdCount - 1));
            if (live[id]) return id;
        end
        return id;
    endfunction

    task automatic send(t_req q, bit has_typed, t_rsp typed);
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        queue_results(q);
        typed_rsp.insert(typed_rsp.size(), typed);
        typed_flag.insert(typed_flag.size(), has_typed);
    endtask

    task automatic idle_gap(int n);
        logic [95:0] junk;
        if (n > 0) begin
            junk = {$urandom, $urandom, $urandom};
            req_ch.valid <= 1'b0;
            req_ch.data  <= junk[$bits(t_req)-1:0];
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_req mkreq(t_opcode op, t_id id, t_time e, t_time n);
        t_req q;
        q.opcode = op; q.timer_id = id; q.expire_time = e; q.now_time = n;
        return q;
    endfunction

    function automatic void add_row(t_req q, bit ht, t_rsp r);
        t_row w;
        w.req = q; w.has_typed = ht; w.typed = r;
        rows.insert(rows.size(), w);
    endfunction

    // Stimulus
    initial begin
        t_req q;
        int   op_pick;
        errors = 0;
        stim_done = 1'b0;
        heap_n = 0;
        foreach (live[i]) live[i] = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(mkreq(OP_TICK, 6'd0, '0, '0), 1, mk(ST_NONE, '0, '0, 1'b1));
        add_row(mkreq(OP_ADJUST, 6'd5, 32'd1, '0), 1, mk(ST_UNKNOWN, '0, '0, 1'b1));
        add_row(mkreq(OP_DELETE, 6'd63, '0, '1), 1, mk(ST_UNKNOWN, '0, '0, 1'b1));
        add_row(mkreq(OP_ADD, 6'd0, '1, '0), 1, mk(ST_DONE, '0, '0, 1'b1));
        add_row(mkreq(OP_ADD, 6'd0, 32'd3, '0), 1, mk(ST_IN_USE, '0, '0, 1'b1));
        add_row(mkreq(OP_ADD, 6'd63, '0, '1), 1, mk(ST_DONE, '0, '0, 1'b1));
        add_row(mkreq(OP_ADD, 6'd21, 32'd10, '0), 0, '0);
        add_row(mkreq(OP_ADD, 6'd42, 32'd10, '0), 0, '0);
        add_row(mkreq(OP_ADD, 6'd7, 32'd10, '0), 0, '0);
        add_row(mkreq(OP_ADJUST, 6'd0, 32'd5, '0), 0, '0);
        add_row(mkreq(OP_ADJUST, 6'd63, '1, '0), 0, '0);
        add_row(mkreq(OP_TICK, 6'd0, '0, 32'd9), 0, '0);
        add_row(mkreq(OP_DELETE, 6'd42, '0, '0), 0, '0);
        add_row(mkreq(OP_TICK, 6'd0, '0, 32'd10), 0, '0);
        add_row(mkreq(OP_TICK, 6'd0, '0, '1), 0, '0);
        add_row(mkreq(OP_TICK, 6'd0, '0, '1), 1, mk(ST_NONE, '0, '0, 1'b1));
        foreach (rows[i]) begin
            send(rows[i].req, rows[i].has_typed, rows[i].typed);
            idle_gap(gap_len());
        end

        // Fill to capacity, then one add too many
        for (int i = 0; i < IdCount; i++) begin
            if (!live[i]) send(mkreq(OP_ADD, t_id'(i), rnd_time(), '0), 0, '0);
            idle_gap(gap_len());
        end
        send(mkreq(OP_ADD, t_id'(0), '0, '0), 1, mk(ST_IN_USE, '0, '0, 1'b1));
        // Full heap with every id live: in-use wins; drain it all in one tick
        send(mkreq(OP_TICK, '0, '0, '1), 0, '0);

        // Pause until the queue is drained
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);

        for (int n = 0; n < 70; n++) begin
            op_pick = $urandom_range(0, 9);
            if (op_pick < 4) q = mkreq(OP_ADD, t_id'($urandom), rnd_time(), t_time'($urandom));
            else if (op_pick < 6) q = mkreq(OP_ADJUST, live_id(), rnd_time(), t_time'($urandom));
            else if (op_pick < 8) q = mkreq(OP_DELETE, live_id(), t_time'($urandom), rnd_time());
            else q = mkreq(OP_TICK, t_id'($urandom), t_time'($urandom), rnd_time());
            send(q, 0, '0);
            idle_gap(gap_len());
        end
        req_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result sink with random backpressure and one long hold-off
    initial begin
        int wait_n;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        repeat (300) @(posedge i_clk);
        forever begin
            wait_n = gap_len();
            if (wait_n > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Check each accepted result
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0) begin
                $error("unexpected result status=%0d", got.status);
                errors = errors + 1;
            end else begin
                want = pending_rsp.pop_front();
                if (want.last && typed_flag.size() != 0) begin
                    if (typed_flag.pop_front() && typed_rsp[0] != got) begin
                        $error("typed row: status exp %0d act %0d",
                               typed_rsp[0].status, got.status);
                        errors = errors + 1;
                    end
                    void'(typed_rsp.pop_front());
                end
                if (got.status !== want.status) begin
                    $error("status exp %0d act %0d", want.status, got.status);
                    errors = errors + 1;
                end
                if (got.expired_id !== want.expired_id) begin
                    $error("expired_id exp %0d act %0d", want.expired_id, got.expired_id);
                    errors = errors + 1;
                end
                if (got.expired_time !== want.expired_time) begin
                    $error("expired_time exp %0h act %0h", want.expired_time, got.expired_time);
                    errors = errors + 1;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d act %0d", want.last, got.last);
                    errors = errors + 1;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("** min_heap_timer_queue_core: FAILED **");
            $finish;
        end
    end

    // End of run
    initial begin
        idle_cycles = 0;
        @(posedge i_rst_n);
        wait (stim_done);
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("** min_heap_timer_queue_core: PASSED **");
        else
            $display("** min_heap_timer_queue_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
hdl/mhtq_pkg.sv
hdl/mhtq_if.sv
hdl/mhtq_ram.sv
hdl/min_heap_timer_queue_core.sv
dv/tb.sv
